// ----- hw/rtl/doubly_linked_list_manager_macros.svh -----
// Assertion macros shared by the list manager RTL.
`ifndef DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH
`define DOUBLY_LINKED_LIST_MANAGER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DLLM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DLLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dllm_pkg.sv -----
// Shared types and constants of the doubly linked list manager.
package dllm_pkg;

    localparam int MODE_W = 3;
    localparam int NODE_W = 6;
    localparam int LEN_W  = 7;

    localparam logic [MODE_W-1:0] MODE_INS_FIRST  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_LAST   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RM_FIRST   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RM_LAST    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RM_NODE    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] anchor;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [NODE_W-1:0] taken_node;
        logic              found;
        logic [LEN_W-1:0]  length;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TGT,
        S_ANC,
        S_WR2,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/dllm_stream_if.sv -----
// Valid/ready stream interface used by the request and response channels.
interface dllm_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dllm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module dllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/doubly_linked_list_manager.sv -----
// Top level of the doubly linked list manager: sequencer, link memories and result register.
// The next and previous links live in two RAMs of POOL_NODES entries with one read and one
// write port each. After reset the block runs a clearing pass over all POOL_NODES entries
// during which no request is taken. A request then runs through these steps before the
// next request is taken: a read of the named node (or the head or tail), a read of the
// anchor for inserts after or before, a decision state that also writes the node's own
// links, a second write state when neighbouring links change, and an output state that
// waits until the output register is free. One request is in flight at a time; a finished
// result waits in an output register while the next request is already being taken.
`include "doubly_linked_list_manager_macros.svh"

module doubly_linked_list_manager
    import dllm_pkg::*;
#(
    parameter int POOL_NODES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dllm_stream_if.sink   i_req,
    dllm_stream_if.source o_rsp
);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int ADDR_W = $clog2(POOL_NODES);
    localparam int CMP_W  = (LINK_W > NODE_W) ? LINK_W : NODE_W;
    localparam int CNT_W  = (LINK_W > LEN_W) ? LINK_W : LEN_W;
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_NODES);
    localparam logic [CMP_W-1:0]  POOL_CMP  = CMP_W'(POOL_NODES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_NODES - 1);

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [MODE_W-1:0] r_mode;
    logic [NODE_W-1:0] r_node, r_anchor;
    logic [LINK_W-1:0] r_head, n_head, r_tail, n_tail, r_count, n_count;
    logic [LINK_W-1:0] r_t_next, r_t_prev;

    logic              r_w2_nx_en, n_w2_nx_en, r_w2_pv_en, n_w2_pv_en;
    logic [ADDR_W-1:0] r_w2_nx_addr, n_w2_nx_addr, r_w2_pv_addr, n_w2_pv_addr;
    logic [LINK_W-1:0] r_w2_nx_data, n_w2_nx_data, r_w2_pv_data, n_w2_pv_data;

    t_rsp r_res, n_res, r_out;
    logic r_out_valid, n_out_valid;
    logic out_free, decide_fire, need_w2, anchored;

    logic              nx_we, pv_we;
    logic [ADDR_W-1:0] nx_waddr, pv_waddr, rd_addr, w1_addr;
    logic [LINK_W-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic [CMP_W-1:0]  req_cmp, node_cmp, anc_cmp, unl_cmp;
    logic              node_in, anc_in, node_linked, anc_linked, node_bad;
    logic [LINK_W-1:0] node_lk, anc_lk, unl_lk, t_next, t_prev;
    logic [ADDR_W-1:0] node_addr, anc_addr;
    logic [CNT_W-1:0]  len_ext;

    logic err, found, go_first, go_last, go_after, go_before, go_unlink;

    dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nx_rdata)
    );

    dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    assign req_cmp   = CMP_W'(i_req.data.node);
    assign node_cmp  = CMP_W'(r_node);
    assign anc_cmp   = CMP_W'(r_anchor);
    assign node_in   = node_cmp < POOL_CMP;
    assign anc_in    = anc_cmp < POOL_CMP;
    assign node_lk   = node_cmp[LINK_W-1:0];
    assign anc_lk    = anc_cmp[LINK_W-1:0];
    assign node_addr = node_cmp[ADDR_W-1:0];
    assign anc_addr  = anc_cmp[ADDR_W-1:0];
    assign unl_cmp   = CMP_W'(unl_lk);
    assign w1_addr   = go_unlink ? unl_lk[ADDR_W-1:0] : node_addr;

    assign t_next = (r_state == S_ANC) ? r_t_next : nx_rdata;
    assign t_prev = (r_state == S_ANC) ? r_t_prev : pv_rdata;

    assign node_linked = node_in && (node_lk == r_head || t_next != NONE_LINK
                                     || t_prev != NONE_LINK);
    assign anc_linked  = anc_in && (anc_lk == r_head || nx_rdata != NONE_LINK
                                    || pv_rdata != NONE_LINK);
    assign node_bad    = !node_in || node_linked;

    assign anchored    = (r_mode == MODE_INS_AFTER) || (r_mode == MODE_INS_BEFORE);
    assign decide_fire = (r_state == S_TGT && !anchored) || (r_state == S_ANC);
    assign need_w2     = n_w2_nx_en || n_w2_pv_en;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        if (r_state == S_IDLE) begin
            case (i_req.data.mode)
                MODE_RM_FIRST: rd_addr = r_head[ADDR_W-1:0];
                MODE_RM_LAST:  rd_addr = r_tail[ADDR_W-1:0];
                default:       rd_addr = req_cmp[ADDR_W-1:0];
            endcase
        end else begin
            rd_addr = anc_addr;
        end
    end

    always_comb begin
        err       = 1'b0;
        found     = 1'b0;
        go_first  = 1'b0;
        go_last   = 1'b0;
        go_after  = 1'b0;
        go_before = 1'b0;
        go_unlink = 1'b0;
        unl_lk    = node_lk;
        unique case (r_mode)
            MODE_INS_FIRST: begin
                if (node_bad) err = 1'b1;
                else go_first = 1'b1;
            end
            MODE_INS_LAST: begin
                if (node_bad) err = 1'b1;
                else go_last = 1'b1;
            end
            MODE_INS_AFTER: begin
                if (node_bad || !anc_linked) err = 1'b1;
                else if (anc_lk == r_tail) go_last = 1'b1;
                else go_after = 1'b1;
            end
            MODE_INS_BEFORE: begin
                if (node_bad || !anc_linked) err = 1'b1;
                else if (anc_lk == r_head) go_first = 1'b1;
                else go_before = 1'b1;
            end
            MODE_RM_FIRST: begin
                unl_lk = r_head;
                if (r_head == NONE_LINK) err = 1'b1;
                else go_unlink = 1'b1;
            end
            MODE_RM_LAST: begin
                unl_lk = r_tail;
                if (r_tail == NONE_LINK) err = 1'b1;
                else go_unlink = 1'b1;
            end
            MODE_RM_NODE: begin
                if (!node_linked) err = 1'b1;
                else go_unlink = 1'b1;
            end
            MODE_SEARCH: begin
                found = node_linked;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) n_state = S_TGT;
            end
            S_TGT: begin
                if (anchored) n_state = S_ANC;
                else if (need_w2) n_state = S_WR2;
                else n_state = S_OUT;
            end
            S_ANC: begin
                n_state = need_w2 ? S_WR2 : S_OUT;
            end
            S_WR2: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        nx_we        = 1'b0;
        pv_we        = 1'b0;
        nx_waddr     = w1_addr;
        pv_waddr     = w1_addr;
        nx_wdata     = NONE_LINK;
        pv_wdata     = NONE_LINK;
        n_clr        = r_clr;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_w2_nx_en   = r_w2_nx_en;
        n_w2_nx_addr = r_w2_nx_addr;
        n_w2_nx_data = r_w2_nx_data;
        n_w2_pv_en   = r_w2_pv_en;
        n_w2_pv_addr = r_w2_pv_addr;
        n_w2_pv_data = r_w2_pv_data;
        n_res        = r_res;
        len_ext      = CNT_W'(r_count);
        unique case (r_state) inside
            S_CLEAR: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = r_clr;
                pv_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
            end
            S_WR2: begin
                nx_we    = r_w2_nx_en;
                nx_waddr = r_w2_nx_addr;
                nx_wdata = r_w2_nx_data;
                pv_we    = r_w2_pv_en;
                pv_waddr = r_w2_pv_addr;
                pv_wdata = r_w2_pv_data;
            end
            S_TGT, S_ANC: begin
                if (decide_fire) begin
                    n_w2_nx_en       = 1'b0;
                    n_w2_pv_en       = 1'b0;
                    n_res.status     = err;
                    n_res.found      = found;
                    n_res.taken_node = '0;
                    if (go_first) begin
                        nx_we        = 1'b1;
                        nx_wdata     = r_head;
                        pv_we        = 1'b1;
                        n_w2_pv_en   = (r_head != NONE_LINK);
                        n_w2_pv_addr = r_head[ADDR_W-1:0];
                        n_w2_pv_data = node_lk;
                        n_head       = node_lk;
                        if (r_head == NONE_LINK) n_tail = node_lk;
                        n_count      = r_count + 1'b1;
                    end
                    if (go_last) begin
                        nx_we        = 1'b1;
                        pv_we        = 1'b1;
                        pv_wdata     = r_tail;
                        n_w2_nx_en   = (r_tail != NONE_LINK);
                        n_w2_nx_addr = r_tail[ADDR_W-1:0];
                        n_w2_nx_data = node_lk;
                        n_tail       = node_lk;
                        if (r_tail == NONE_LINK) n_head = node_lk;
                        n_count      = r_count + 1'b1;
                    end
                    if (go_after) begin
                        nx_we        = 1'b1;
                        nx_wdata     = nx_rdata;
                        pv_we        = 1'b1;
                        pv_wdata     = anc_lk;
                        n_w2_nx_en   = 1'b1;
                        n_w2_nx_addr = anc_addr;
                        n_w2_nx_data = node_lk;
                        n_w2_pv_en   = 1'b1;
                        n_w2_pv_addr = nx_rdata[ADDR_W-1:0];
                        n_w2_pv_data = node_lk;
                        n_count      = r_count + 1'b1;
                    end
                    if (go_before) begin
                        nx_we        = 1'b1;
                        nx_wdata     = anc_lk;
                        pv_we        = 1'b1;
                        pv_wdata     = pv_rdata;
                        n_w2_nx_en   = 1'b1;
                        n_w2_nx_addr = pv_rdata[ADDR_W-1:0];
                        n_w2_nx_data = node_lk;
                        n_w2_pv_en   = 1'b1;
                        n_w2_pv_addr = anc_addr;
                        n_w2_pv_data = node_lk;
                        n_count      = r_count + 1'b1;
                    end
                    if (go_unlink) begin
                        nx_we            = 1'b1;
                        pv_we            = 1'b1;
                        n_w2_nx_en       = (t_prev != NONE_LINK);
                        n_w2_nx_addr     = t_prev[ADDR_W-1:0];
                        n_w2_nx_data     = t_next;
                        n_w2_pv_en       = (t_next != NONE_LINK);
                        n_w2_pv_addr     = t_next[ADDR_W-1:0];
                        n_w2_pv_data     = t_prev;
                        if (t_prev == NONE_LINK) n_head = t_next;
                        if (t_next == NONE_LINK) n_tail = t_prev;
                        n_count          = r_count - 1'b1;
                        n_res.taken_node = unl_cmp[NODE_W-1:0];
                    end
                    len_ext      = CNT_W'(n_count);
                    n_res.length = len_ext[LEN_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = (r_state == S_OUT && out_free) || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= NONE_LINK;
            r_tail      <= NONE_LINK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_w2_nx_en  <= 1'b0;
            r_w2_pv_en  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_w2_nx_en  <= n_w2_nx_en;
            r_w2_pv_en  <= n_w2_pv_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_mode   <= i_req.data.mode;
            r_node   <= i_req.data.node;
            r_anchor <= i_req.data.anchor;
        end
        if (r_state == S_TGT) begin
            r_t_next <= nx_rdata;
            r_t_prev <= pv_rdata;
        end
        r_w2_nx_addr <= n_w2_nx_addr;
        r_w2_nx_data <= n_w2_nx_data;
        r_w2_pv_addr <= n_w2_pv_addr;
        r_w2_pv_data <= n_w2_pv_data;
        r_res        <= n_res;
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    `DLLM_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= NONE_LINK,
                      "count exceeds pool")
    `DLLM_ASSERT_SAME(a_empty_consistent, i_clk, i_rst_n, 1'b1,
                      ((r_head == NONE_LINK) == (r_count == '0))
                      && ((r_tail == NONE_LINK) == (r_count == '0)),
                      "head, tail and count disagree on an empty list")
    `DLLM_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !decide_fire, $stable(r_count),
                      "count changed outside a decision cycle")
    `DLLM_ASSERT_SAME(a_write_states, i_clk, i_rst_n, nx_we || pv_we,
                      r_state == S_CLEAR || r_state == S_TGT || r_state == S_ANC
                      || r_state == S_WR2,
                      "link write in a state that owns no write")

endmodule
